[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is held
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("port assertion failed");

// concurrent assertion that also holds while reset is held
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("port assertion failed");

`endif

[rtl/vfp_pkg.sv]
`default_nettype none

package vfp_pkg;

  // volume geometry
  localparam int VOL_WIDTH   = 16;
  localparam int VOL_HEIGHT  = 24;
  localparam int VOL_DEPTH   = 16;
  localparam int SLICE_CELLS = VOL_WIDTH * VOL_HEIGHT;
  localparam int VOL_CELLS   = VOL_WIDTH * VOL_HEIGHT * VOL_DEPTH;
  localparam int BASE_CELLS  = 2 * VOL_WIDTH * VOL_DEPTH;

  localparam int X_W      = $clog2(VOL_WIDTH);
  localparam int Y_W      = $clog2(VOL_HEIGHT);
  localparam int Z_W      = $clog2(VOL_DEPTH);
  localparam int ADDR_W   = $clog2(VOL_CELLS);
  localparam int CURSOR_W = $clog2(BASE_CELLS);

  // intensity and arithmetic widths
  localparam int LEVEL_W    = 5;
  localparam int MAX_LEVEL  = 31;
  localparam int NOISE_W    = 8;
  localparam int RADIUS_SQ  = (VOL_DEPTH * VOL_DEPTH) / 4;
  localparam int WEIGHT_W   = $clog2(RADIUS_SQ + 1);
  localparam int SEED_SHIFT = 9;
  localparam int SUM_SHIFT  = 3;
  localparam int SUM_W      = $clog2(9 * MAX_LEVEL + 1);

  // item kinds carried in the input tuser
  typedef enum logic [1:0] {
    ACT_SEED = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_READ = 2'd2
  } action_e;

  // one seed write towards the volume memory
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [LEVEL_W-1:0] level;
  } seed_wr_t;

  // linear address of a cell, slices outermost
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y,
                                                  input logic [Z_W-1:0] z);
    int a;
    a = int'(z) * SLICE_CELLS + int'(y) * VOL_WIDTH + int'(x);
    return ADDR_W'(a);
  endfunction

  // address of the base cell that a cursor value points at
  function automatic logic [ADDR_W-1:0] seed_addr(input logic [CURSOR_W-1:0] c);
    int n;
    int x;
    int z;
    int row;
    int y;
    n   = int'(c);
    x   = n % VOL_WIDTH;
    z   = (n / VOL_WIDTH) % VOL_DEPTH;
    row = n / (VOL_WIDTH * VOL_DEPTH);
    y   = VOL_HEIGHT - 1 - (row % 2);
    return cell_addr(X_W'(x), Y_W'(y), Z_W'(z));
  endfunction

  // radial falloff of the base cell that a cursor value points at
  function automatic logic [WEIGHT_W-1:0] radial_weight(input logic [CURSOR_W-1:0] c);
    int n;
    int xc;
    int zc;
    int d;
    n  = int'(c);
    xc = (n % VOL_WIDTH) - VOL_WIDTH / 2;
    zc = ((n / VOL_WIDTH) % VOL_DEPTH) - VOL_DEPTH / 2;
    d  = RADIUS_SQ - (xc * xc + zc * zc);
    if (d < 0) begin
      d = 0;
    end
    return WEIGHT_W'(d);
  endfunction

endpackage

`default_nettype wire

[rtl/vfp_seed.sv]
`default_nettype none

module vfp_seed (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        seed_en_i,
  input  wire logic [vfp_pkg::NOISE_W-1:0] noise_i,
  output vfp_pkg::seed_wr_t                seed_o
);
  import vfp_pkg::*;

  logic [CURSOR_W-1:0]         cursor_q, cursor_d;
  logic [WEIGHT_W-1:0]         weight_q;
  logic [WEIGHT_W+NOISE_W-1:0] prod;
  logic [WEIGHT_W+NOISE_W-1:0] scaled;

  // cursor walks the base rows and wraps after the last one
  always_comb begin
    cursor_d = cursor_q;
    if (seed_en_i) begin
      if (int'(cursor_q) == BASE_CELLS - 1) begin
        cursor_d = '0;
      end else begin
        cursor_d = cursor_q + CURSOR_W'(1);
      end
    end
  end

  // the falloff follows the cursor, so only one product sits in the write path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      weight_q <= radial_weight('0);
    end else if (seed_en_i) begin
      cursor_q <= cursor_d;
      weight_q <= radial_weight(cursor_d);
    end
  end

  // scaled noise, saturated to the intensity range
  assign prod   = (WEIGHT_W+NOISE_W)'(weight_q) * (WEIGHT_W+NOISE_W)'(noise_i);
  assign scaled = prod >> SEED_SHIFT;

  assign seed_o.addr  = seed_addr(cursor_q);
  assign seed_o.level = (scaled > (WEIGHT_W+NOISE_W)'(MAX_LEVEL)) ?
                        LEVEL_W'(MAX_LEVEL) : scaled[LEVEL_W-1:0];

endmodule

`default_nettype wire

[rtl/volumetric_fire_propagation_unit.sv]
// Volumetric fire propagation unit: a 16x24x16 volume of 5-bit intensities
// held in one single-port-write, single-port-read memory.
// Input channel (s_axis): tuser selects the item kind - seed write, run pass
// or voxel read. Seed writes give no result. A read gives one result
// (voxel, pass_done = 0) through the memory read register and the output
// register, and reads can follow each other every cycle while the receiver
// takes results. A run item sweeps the 14x22x14 interior; each interior cell
// gets six reads (the cell and five neighbours), an accumulate step and a
// write back, and after the pass one result with voxel 0 and pass_done 1 is
// offered. No item is taken during a pass. A run item is held off until an
// earlier read has left the memory read register.
// Output channel (m_axis): one output register; while the receiver stalls,
// the result holds and further reads stop at one in flight.
// Reset: the base cursor returns to zero and a clearing pass writes zero
// into all 6144 cells, one per cycle; s_axis_tready stays low until the
// clearing pass is through.
`default_nettype none

module volumetric_fire_propagation_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // noise[7:0], pos_x[11:8], pos_y[16:12], pos_z[20:17], zero fill
  input  wire logic [23:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // voxel[4:0], zero fill
  output      logic [7:0]  m_axis_tdata,
  // pass_done[0]
  output      logic [0:0]  m_axis_tuser
);
  import vfp_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // sweep steps: a read is issued in the steps named after it,
  // its data is added in the step after it
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_RD_L = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RD_R = 3'd1;
  localparam logic [STEP_W-1:0] STEP_RD_C = 3'd2;
  localparam logic [STEP_W-1:0] STEP_RD_B = 3'd3;
  localparam logic [STEP_W-1:0] STEP_RD_F = 3'd4;
  localparam logic [STEP_W-1:0] STEP_RD_K = 3'd5;
  localparam logic [STEP_W-1:0] STEP_ACC  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_WR   = 3'd7;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [X_W-1:0]      rx_q, rx_d;
  logic [Y_W-1:0]      ry_q, ry_d;
  logic [Z_W-1:0]      rz_q, rz_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                rd_pend_q, rd_pend_d;
  logic                rd_zero_q, rd_zero_d;
  logic                out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]  out_voxel_q, out_voxel_d;
  logic                out_done_q, out_done_d;

  logic [LEVEL_W-1:0]  mem [VOL_CELLS];
  logic [LEVEL_W-1:0]  rdata_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [LEVEL_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;

  action_e             act;
  logic                in_xfer;
  logic                out_free;
  logic                seed_en;
  logic                read_en;
  logic [NOISE_W-1:0]  in_noise;
  logic [X_W-1:0]      in_x;
  logic [Y_W-1:0]      in_y;
  logic [Z_W-1:0]      in_z;
  logic                in_range;
  seed_wr_t            seed_wr;

  logic [X_W-1:0]      ax;
  logic [Y_W-1:0]      ay;
  logic [Z_W-1:0]      az;
  logic [ADDR_W-1:0]   run_addr;
  logic [SUM_W-1:0]    d1, d2, d3, term;
  logic [SUM_W-1:0]    shifted;
  logic [LEVEL_W-1:0]  new_level;

  // input unpacking
  assign act      = action_e'(s_axis_tuser);
  assign in_noise = s_axis_tdata[7:0];
  assign in_x     = s_axis_tdata[11:8];
  assign in_y     = s_axis_tdata[16:12];
  assign in_z     = s_axis_tdata[20:17];
  assign in_range = (int'(in_x) < VOL_WIDTH) && (int'(in_y) < VOL_HEIGHT) &&
                    (int'(in_z) < VOL_DEPTH);

  // handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && (!rd_pend_q || out_free) &&
                         !((act == ACT_RUN) && rd_pend_q);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign seed_en       = in_xfer && (act == ACT_SEED);
  assign read_en       = in_xfer && (act == ACT_READ);

  vfp_seed u_seed (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_en_i (seed_en),
    .noise_i   (in_noise),
    .seed_o    (seed_wr)
  );

  // neighbour selection for the sweep
  always_comb begin
    ax = rx_q;
    ay = ry_q + Y_W'(1);
    az = rz_q;
    case (step_q)
      STEP_RD_L: ax = rx_q - X_W'(1);
      STEP_RD_R: ax = rx_q + X_W'(1);
      STEP_RD_C: ay = ry_q;
      STEP_RD_B: ;
      STEP_RD_F: az = rz_q - Z_W'(1);
      STEP_RD_K: az = rz_q + Z_W'(1);
      default:   ay = ry_q;
    endcase
  end
  assign run_addr = cell_addr(ax, ay, az);

  // weighted term of the value read in the previous step
  assign d1 = SUM_W'(rdata_q);
  assign d2 = d1 << 1;
  assign d3 = d2 + d1;
  always_comb begin
    case (step_q)
      STEP_RD_B: term = ry_q[0] ? d3 : d2;
      STEP_RD_F: term = rz_q[0] ? d2 : d1;
      default:   term = d1;
    endcase
  end

  // averaged value, saturated
  assign shifted   = sum_q >> SUM_SHIFT;
  assign new_level = (shifted > SUM_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) :
                     shifted[LEVEL_W-1:0];

  // sequencer, memory port control and output register
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    step_d      = step_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    rz_d        = rz_q;
    sum_d       = sum_q;
    rd_pend_d   = rd_pend_q;
    rd_zero_d   = rd_zero_q;
    out_valid_d = out_valid_q;
    out_voxel_d = out_voxel_q;
    out_done_d  = out_done_q;
    mem_we      = 1'b0;
    mem_waddr   = seed_wr.addr;
    mem_wdata   = seed_wr.level;
    mem_re      = 1'b0;
    mem_raddr   = cell_addr(in_x, in_y, in_z);

    // output register: take a finished read or the pass completion
    if (out_free) begin
      out_valid_d = 1'b0;
      if (rd_pend_q) begin
        out_valid_d = 1'b1;
        out_voxel_d = rd_zero_q ? '0 : rdata_q;
        out_done_d  = 1'b0;
        rd_pend_d   = 1'b0;
      end else if (state_q == ST_DONE) begin
        out_valid_d = 1'b1;
        out_voxel_d = '0;
        out_done_d  = 1'b1;
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (int'(clr_q) == VOL_CELLS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (seed_en) begin
          mem_we = 1'b1;
        end
        if (read_en) begin
          mem_re    = in_range;
          rd_pend_d = 1'b1;
          rd_zero_d = !in_range;
        end
        if (in_xfer && (act == ACT_RUN)) begin
          state_d = ST_RUN;
          step_d  = STEP_RD_L;
          rx_d    = X_W'(1);
          ry_d    = Y_W'(1);
          rz_d    = Z_W'(1);
          sum_d   = '0;
        end
      end
      ST_RUN: begin
        mem_raddr = run_addr;
        mem_re    = (step_q < STEP_ACC);
        if ((step_q != STEP_RD_L) && (step_q != STEP_WR)) begin
          sum_d = sum_q + term;
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_WR) begin
          mem_we    = 1'b1;
          mem_waddr = run_addr;
          mem_wdata = new_level;
          sum_d     = '0;
          step_d    = STEP_RD_L;
          if (int'(rx_q) == VOL_WIDTH - 2) begin
            rx_d = X_W'(1);
            if (int'(ry_q) == VOL_HEIGHT - 2) begin
              ry_d = Y_W'(1);
              if (int'(rz_q) == VOL_DEPTH - 2) begin
                state_d = ST_DONE;
              end else begin
                rz_d = rz_q + Z_W'(1);
              end
            end else begin
              ry_d = ry_q + Y_W'(1);
            end
          end else begin
            rx_d = rx_q + X_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // volume memory, registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      step_q      <= STEP_RD_L;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rx_q        <= rx_d;
    ry_q        <= ry_d;
    rz_q        <= rz_d;
    sum_q       <= sum_d;
    rd_zero_q   <= rd_zero_d;
    out_voxel_q <= out_voxel_d;
    out_done_q  <= out_done_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8-LEVEL_W){1'b0}}, out_voxel_q};
  assign m_axis_tuser  = out_done_q;

endmodule

`default_nettype wire

[rtl/vfp_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module vfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);
  import vfp_pkg::*;

  // a stalled result holds
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // the pass completion carries no intensity
  `ASSERT_RST(a_done_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'd0)

  // a run transfer stops the input for the sweep
  `ASSERT_RST(a_run_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_RUN) |=> !s_axis_tready)

  // the clearing pass keeps the input closed just after reset
  `ASSERT_ALWAYS(a_clear_busy, clk_i, !rst_ni |=> !s_axis_tready)

  // no result during reset
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule

bind volumetric_fire_propagation_unit vfp_checker u_vfp_checker (.*);

`default_nettype wire

[verif/volumetric_fire_propagation_unit_tb.sv]
`timescale 1ns / 100ps

module volumetric_fire_propagation_unit_tb;
  import vfp_pkg::*;

  // item kind that the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // longest quiet spell: a full pass plus reset clearing, taken several times over
  localparam int STALL_LIMIT = 150000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_PRINTED = 100;
  localparam int FIRE_ROUNDS = 8;
  localparam int ROUND_ITEMS = 58;

  typedef struct packed {
    logic [LEVEL_W-1:0] voxel;
    logic               pass_done;
  } fire_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  // predicted volume and seeding position
  logic [LEVEL_W-1:0] fire_level [VOL_CELLS];
  int unsigned        base_next;
  fire_result_t       fire_results_due [$];
  fire_result_t       oldest_due;
  int                 mismatches;
  int                 idle_cycles;
  bit                 quiet_link;

  volumetric_fire_propagation_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int vox_index(input int x, input int y, input int z);
    return (z * VOL_HEIGHT + y) * VOL_WIDTH + x;
  endfunction

  // base cell: radial falloff scaled by the noise byte
  function automatic void seed_base(input logic [7:0] noise);
    int x;
    int y;
    int z;
    int xc;
    int zc;
    int heat;
    int lvl;
    x    = base_next % VOL_WIDTH;
    z    = (base_next / VOL_WIDTH) % VOL_DEPTH;
    y    = VOL_HEIGHT - 1 - ((base_next / (VOL_WIDTH * VOL_DEPTH)) % 2);
    xc   = x - VOL_WIDTH / 2;
    zc   = z - VOL_DEPTH / 2;
    heat = (VOL_DEPTH * VOL_DEPTH) / 4 - (xc * xc + zc * zc);
    if (heat < 0) begin
      heat = 0;
    end
    lvl = (heat * int'(noise)) >> SEED_SHIFT;
    if (lvl > MAX_LEVEL) begin
      lvl = MAX_LEVEL;
    end
    fire_level[vox_index(x, y, z)] = LEVEL_W'(lvl);
    base_next = (base_next + 1) % BASE_CELLS;
  endfunction

  // in-place sweep of the interior, rows below feed the row above
  function automatic void burn_pass();
    int sum;
    int wy;
    int wz;
    for (int z = 1; z < VOL_DEPTH - 1; z++) begin
      wz = (z % 2) + 1;
      for (int y = 1; y < VOL_HEIGHT - 1; y++) begin
        wy = (y % 2) + 2;
        for (int x = 1; x < VOL_WIDTH - 1; x++) begin
          sum = int'(fire_level[vox_index(x - 1, y + 1, z)])
              + int'(fire_level[vox_index(x + 1, y + 1, z)])
              + wy * int'(fire_level[vox_index(x, y, z)])
              + wz * int'(fire_level[vox_index(x, y + 1, z)])
              + int'(fire_level[vox_index(x, y + 1, z - 1)])
              + int'(fire_level[vox_index(x, y + 1, z + 1)]);
          sum = sum >> SUM_SHIFT;
          if (sum > MAX_LEVEL) begin
            sum = MAX_LEVEL;
          end
          fire_level[vox_index(x, y, z)] = LEVEL_W'(sum);
        end
      end
    end
  endfunction

  // update the prediction for one accepted item
  function automatic void predict_item(input logic [1:0] act, input logic [7:0] noise,
                                       input logic [3:0] px, input logic [4:0] py,
                                       input logic [3:0] pz);
    fire_result_t res;
    res = '0;
    case (act)
      ACT_SEED: begin
        seed_base(noise);
      end
      ACT_RUN: begin
        burn_pass();
        res.pass_done = 1'b1;
        fire_results_due.push_back(res);
      end
      ACT_READ: begin
        if (int'(px) < VOL_WIDTH && int'(py) < VOL_HEIGHT && int'(pz) < VOL_DEPTH) begin
          res.voxel = fire_level[vox_index(int'(px), int'(py), int'(pz))];
        end
        fire_results_due.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int draw_wait();
    if (quiet_link || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // one input transfer; entered and left just after a falling edge
  task automatic send_item(input logic [1:0] act, input logic [7:0] noise,
                           input logic [3:0] px, input logic [4:0] py,
                           input logic [3:0] pz);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = act;
    s_axis_tdata  = {3'b000, pz, py, px, noise};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(act, noise, px, py, pz);
    @(negedge clk_i);
  endtask

  task automatic send_read(input int x, input int y, input int z);
    send_item(ACT_READ, 8'($urandom), 4'(x), 5'(y), 4'(z));
  endtask

  // hold the sender until every predicted result has been seen
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (fire_results_due.size() != 0) @(negedge clk_i);
  endtask

  // a fresh volume reads back as zero everywhere
  task automatic test_cleared_volume();
    quiet_link = 1'b1;
    send_read(0, 0, 0);
    send_read(15, 23, 15);
    send_read(8, 23, 8);
    send_read(7, 12, 3);
    quiet_link = 1'b0;
  endtask

  // rows past the bottom of the volume read as zero
  task automatic test_out_of_range_reads();
    send_read(0, 24, 0);
    send_read(15, 31, 15);
    send_read(5, 27, 9);
  endtask

  // noise extremes, then an unused code that must change nothing
  task automatic test_seed_and_ignore();
    send_item(ACT_SEED, 8'h00, 4'h0, 5'h00, 4'h0);
    send_item(ACT_SEED, 8'hff, 4'hf, 5'h1f, 4'hf);
    send_item(ACT_UNUSED, 8'hff, 4'hf, 5'h1f, 4'hf);
    send_item(ACT_UNUSED, 8'h00, 4'h0, 5'h00, 4'h0);
    send_read(0, 23, 0);
    send_read(1, 23, 0);
  endtask

  // two passes over a barely seeded volume, with reads in between
  task automatic test_first_passes();
    wait_drained();
    send_item(ACT_RUN, 8'h00, 4'h0, 5'h00, 4'h0);
    send_read(1, 1, 1);
    send_read(14, 22, 14);
    send_item(ACT_RUN, 8'hff, 4'hf, 5'h1f, 4'hf);
    send_read(8, 22, 8);
  endtask

  // reads, seeds and ignored codes mixed between passes
  task automatic random_item();
    int          sel;
    logic [7:0]  nz;
    logic [3:0]  px;
    logic [4:0]  py;
    logic [3:0]  pz;
    sel = $urandom_range(0, 99);
    nz  = 8'($urandom);
    px  = 4'($urandom);
    pz  = 4'($urandom);
    py  = 5'($urandom_range(0, 23));
    if (sel < 55) begin
      if ($urandom_range(0, 1) == 1) begin
        py = 5'($urandom_range(12, 23));
      end
      send_item(ACT_READ, nz, px, py, pz);
    end else if (sel < 65) begin
      send_item(ACT_READ, nz, px, 5'($urandom_range(0, 31)), pz);
    end else if (sel < 90) begin
      if ($urandom_range(0, 3) != 0) begin
        nz = 8'($urandom_range(128, 255));
      end
      send_item(ACT_SEED, nz, px, 5'($urandom), pz);
    end else begin
      send_item(ACT_UNUSED, nz, px, 5'($urandom), pz);
    end
  endtask

  // full base fill, then repeated passes with probing in between
  task automatic test_random_fire();
    for (int i = 0; i < BASE_CELLS; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item(ACT_SEED, 8'($urandom), 4'($urandom), 5'($urandom), 4'($urandom));
      end else begin
        send_item(ACT_SEED, 8'($urandom_range(128, 255)), 4'($urandom), 5'($urandom),
                  4'($urandom));
      end
    end
    for (int r = 0; r < FIRE_ROUNDS; r++) begin
      quiet_link = (r % 3 == 0);
      if ($urandom_range(0, 1) == 1) begin
        wait_drained();
      end
      send_item(ACT_RUN, 8'($urandom), 4'($urandom), 5'($urandom), 4'($urandom));
      repeat (ROUND_ITEMS) random_item();
    end
    quiet_link = 1'b0;
  endtask

  // receiver: random stalls per result
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (fire_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result voxel %0d pass_done %0d",
                                  m_axis_tdata[LEVEL_W-1:0], m_axis_tuser[0]));
      end else begin
        oldest_due = fire_results_due.pop_front();
        if (m_axis_tdata[LEVEL_W-1:0] !== oldest_due.voxel) begin
          report_mismatch($sformatf("voxel got %0d want %0d",
                                    m_axis_tdata[LEVEL_W-1:0], oldest_due.voxel));
        end
        if (m_axis_tuser[0] !== oldest_due.pass_done) begin
          report_mismatch($sformatf("pass_done got %0d want %0d",
                                    m_axis_tuser[0], oldest_due.pass_done));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("volumetric_fire_propagation_unit regression: fail");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_SEED;
    m_axis_tready = 1'b0;
    quiet_link    = 1'b0;
    mismatches    = 0;
    idle_cycles   = 0;
    base_next     = 0;
    foreach (fire_level[i]) begin
      fire_level[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_cleared_volume();
    test_out_of_range_reads();
    test_seed_and_ignore();
    test_first_passes();
    test_random_fire();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("volumetric_fire_propagation_unit regression: pass");
    end else begin
      $display("volumetric_fire_propagation_unit regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/vfp_pkg.sv
rtl/vfp_seed.sv
rtl/volumetric_fire_propagation_unit.sv
rtl/vfp_checker.sv
verif/volumetric_fire_propagation_unit_tb.sv
